// File: design/iice_pkg.sv
// Shared types, codes and helpers of the implied-mode instruction executor.
package iice_pkg;

    // Status byte bits, NV-BDIZC order
    localparam logic [7:0] FLAG_C = 8'h01;
    localparam logic [7:0] FLAG_Z = 8'h02;
    localparam logic [7:0] FLAG_I = 8'h04;
    localparam logic [7:0] FLAG_D = 8'h08;
    localparam logic [7:0] FLAG_B = 8'h10;
    localparam logic [7:0] FLAG_U = 8'h20;
    localparam logic [7:0] FLAG_V = 8'h40;
    localparam logic [7:0] FLAG_N = 8'h80;

    localparam logic [7:0]  STACK_PAGE = 8'h01;
    localparam logic [15:0] VEC_IRQ_LO = 16'hFFFE;
    localparam logic [15:0] VEC_IRQ_HI = 16'hFFFF;

    // Instruction codes as carried in req_type
    typedef enum logic [4:0] {
        INSTR_BRK = 5'd0,  INSTR_CLC = 5'd1,  INSTR_CLI = 5'd2,  INSTR_CLV = 5'd3,
        INSTR_CLD = 5'd4,  INSTR_SEC = 5'd5,  INSTR_SEI = 5'd6,  INSTR_SED = 5'd7,
        INSTR_NOP = 5'd8,  INSTR_TAX = 5'd9,  INSTR_TAY = 5'd10, INSTR_TXA = 5'd11,
        INSTR_TYA = 5'd12, INSTR_INX = 5'd13, INSTR_INY = 5'd14, INSTR_DEX = 5'd15,
        INSTR_DEY = 5'd16, INSTR_RTI = 5'd17, INSTR_RTS = 5'd18, INSTR_TXS = 5'd19,
        INSTR_TSX = 5'd20, INSTR_PHA = 5'd21, INSTR_PHP = 5'd22, INSTR_PLA = 5'd23,
        INSTR_PLP = 5'd24
    } t_instr;

    // Controller state
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Bus address source
    typedef enum logic [1:0] {
        ADDR_PC,
        ADDR_STACK,
        ADDR_VEC_LO,
        ADDR_VEC_HI
    } t_addr_sel;

    // Write data source; NONE marks a read cycle
    typedef enum logic [2:0] {
        WD_NONE,
        WD_PCH,
        WD_PCL,
        WD_PBRK,
        WD_ACC,
        WD_STATUS
    } t_wdata_sel;

    // Register file effect of one bus cycle
    typedef enum logic [4:0] {
        REG_NONE,
        REG_CLC, REG_CLI, REG_CLV, REG_CLD,
        REG_SEC, REG_SEI, REG_SED,
        REG_TAX, REG_TAY, REG_TXA, REG_TYA,
        REG_INX, REG_INY, REG_DEX, REG_DEY,
        REG_TXS, REG_TSX,
        REG_PLA, REG_PLP, REG_RTI_P
    } t_reg_op;

    // Program counter byte loads from the pulled bytes
    typedef enum logic [2:0] {
        PCLD_NONE,
        PCLD_LO_B1,
        PCLD_LO_B2,
        PCLD_HI_B2,
        PCLD_HI_B3
    } t_pc_load;

    // Request and response payloads
    typedef struct packed {
        logic [4:0] req_type;
        logic [7:0] pull_byte_first;
        logic [7:0] pull_byte_second;
        logic [7:0] pull_byte_third;
    } t_req;

    typedef struct packed {
        logic [15:0] bus_address;
        logic        bus_is_write;
        logic [7:0]  bus_write_data;
        logic        last_cycle;
        logic [7:0]  acc_out;
        logic [7:0]  index_x_out;
        logic [7:0]  index_y_out;
        logic [7:0]  stack_ptr_out;
        logic [7:0]  status_out;
        logic [15:0] prog_counter_out;
    } t_rsp;

    // Controller to datapath command for one clock
    typedef struct packed {
        logic       load;
        logic       step;
        logic       last;
        t_addr_sel  addr_sel;
        t_wdata_sel wdata_sel;
        t_reg_op    reg_op;
        t_pc_load   pc_load;
        logic       pc_inc;
        logic       sp_inc;
        logic       sp_dec;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Update N and Z of a status byte from a value
    function automatic logic [7:0] f_set_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r = p & ~(FLAG_N | FLAG_Z);
        if (v == 8'h00) r = r | FLAG_Z;
        if (v[7]) r = r | FLAG_N;
        return r;
    endfunction

endpackage

// File: design/iice_ctrl.sv
// Controller: request handshake and per-cycle sequencing of each instruction.
module iice_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic [4:0]          i_req_type,
    output logic                o_req_stall,
    input  iice_pkg::t_dp_status i_status,
    output iice_pkg::t_cmd      o_cmd
);
    import iice_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_step;
    logic [4:0] r_op;
    logic       accept;
    logic       op_known;

    assign o_req_stall = (r_state != ST_IDLE);
    assign accept      = i_req_valid && (r_state == ST_IDLE);
    // Codes past PLP are dropped without any bus cycle
    assign op_known    = (i_req_type <= INSTR_PLP);

    // State, step counter and latched opcode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 3'd0;
            r_op    <= 5'd0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_op   <= i_req_type;
                r_step <= 3'd0;
            end else if (o_cmd.step) begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && op_known) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (o_cmd.step && o_cmd.last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Command decode per instruction and step
    always_comb begin
        o_cmd           = '0;
        o_cmd.addr_sel  = ADDR_PC;
        o_cmd.wdata_sel = WD_NONE;
        o_cmd.reg_op    = REG_NONE;
        o_cmd.pc_load   = PCLD_NONE;
        o_cmd.load      = accept;
        o_cmd.step      = (r_state == ST_EXEC) && i_status.out_free;

        if (r_step == 3'd0) begin
            // opcode fetch
            o_cmd.pc_inc = 1'b1;
        end else begin
            unique case (t_instr'(r_op))
                INSTR_BRK: begin
                    unique case (r_step)
                        3'd1: o_cmd.pc_inc = 1'b1;
                        3'd2: begin
                            o_cmd.addr_sel  = ADDR_STACK;
                            o_cmd.wdata_sel = WD_PCH;
                            o_cmd.sp_dec    = 1'b1;
                        end
                        3'd3: begin
                            o_cmd.addr_sel  = ADDR_STACK;
                            o_cmd.wdata_sel = WD_PCL;
                            o_cmd.sp_dec    = 1'b1;
                        end
                        3'd4: begin
                            o_cmd.addr_sel  = ADDR_STACK;
                            o_cmd.wdata_sel = WD_PBRK;
                            o_cmd.sp_dec    = 1'b1;
                        end
                        3'd5: begin
                            o_cmd.addr_sel = ADDR_VEC_LO;
                            o_cmd.pc_load  = PCLD_LO_B1;
                        end
                        default: begin
                            o_cmd.addr_sel = ADDR_VEC_HI;
                            o_cmd.pc_load  = PCLD_HI_B2;
                            o_cmd.reg_op   = REG_SEI;
                            o_cmd.last     = 1'b1;
                        end
                    endcase
                end
                INSTR_RTI: begin
                    if (r_step != 3'd1) o_cmd.addr_sel = ADDR_STACK;
                    unique case (r_step)
                        3'd1: ;
                        3'd2: o_cmd.sp_inc = 1'b1;
                        3'd3: begin
                            o_cmd.reg_op = REG_RTI_P;
                            o_cmd.sp_inc = 1'b1;
                        end
                        3'd4: begin
                            o_cmd.pc_load = PCLD_LO_B2;
                            o_cmd.sp_inc  = 1'b1;
                        end
                        default: begin
                            o_cmd.pc_load = PCLD_HI_B3;
                            o_cmd.last    = 1'b1;
                        end
                    endcase
                end
                INSTR_RTS: begin
                    unique case (r_step)
                        3'd1: ;
                        3'd2: begin
                            o_cmd.addr_sel = ADDR_STACK;
                            o_cmd.sp_inc   = 1'b1;
                        end
                        3'd3: begin
                            o_cmd.addr_sel = ADDR_STACK;
                            o_cmd.pc_load  = PCLD_LO_B1;
                            o_cmd.sp_inc   = 1'b1;
                        end
                        3'd4: begin
                            o_cmd.addr_sel = ADDR_STACK;
                            o_cmd.pc_load  = PCLD_HI_B2;
                        end
                        default: begin
                            // fetch past the return address
                            o_cmd.pc_inc = 1'b1;
                            o_cmd.last   = 1'b1;
                        end
                    endcase
                end
                INSTR_PHA, INSTR_PHP: begin
                    if (r_step != 3'd1) begin
                        o_cmd.addr_sel  = ADDR_STACK;
                        o_cmd.wdata_sel = (t_instr'(r_op) == INSTR_PHA) ? WD_ACC : WD_STATUS;
                        o_cmd.sp_dec    = 1'b1;
                        o_cmd.last      = 1'b1;
                    end
                end
                INSTR_PLA, INSTR_PLP: begin
                    unique case (r_step)
                        3'd1: ;
                        3'd2: begin
                            o_cmd.addr_sel = ADDR_STACK;
                            o_cmd.sp_inc   = 1'b1;
                        end
                        default: begin
                            o_cmd.addr_sel = ADDR_STACK;
                            o_cmd.reg_op   = (t_instr'(r_op) == INSTR_PLA) ? REG_PLA : REG_PLP;
                            o_cmd.last     = 1'b1;
                        end
                    endcase
                end
                default: begin
                    // remaining implied instructions: register work on the dummy read
                    o_cmd.last = 1'b1;
                    unique case (t_instr'(r_op))
                        INSTR_CLC: o_cmd.reg_op = REG_CLC;
                        INSTR_CLI: o_cmd.reg_op = REG_CLI;
                        INSTR_CLV: o_cmd.reg_op = REG_CLV;
                        INSTR_CLD: o_cmd.reg_op = REG_CLD;
                        INSTR_SEC: o_cmd.reg_op = REG_SEC;
                        INSTR_SEI: o_cmd.reg_op = REG_SEI;
                        INSTR_SED: o_cmd.reg_op = REG_SED;
                        INSTR_TAX: o_cmd.reg_op = REG_TAX;
                        INSTR_TAY: o_cmd.reg_op = REG_TAY;
                        INSTR_TXA: o_cmd.reg_op = REG_TXA;
                        INSTR_TYA: o_cmd.reg_op = REG_TYA;
                        INSTR_INX: o_cmd.reg_op = REG_INX;
                        INSTR_INY: o_cmd.reg_op = REG_INY;
                        INSTR_DEX: o_cmd.reg_op = REG_DEX;
                        INSTR_DEY: o_cmd.reg_op = REG_DEY;
                        INSTR_TXS: o_cmd.reg_op = REG_TXS;
                        INSTR_TSX: o_cmd.reg_op = REG_TSX;
                        default:   o_cmd.reg_op = REG_NONE;
                    endcase
                end
            endcase
        end
    end

endmodule

// File: design/iice_dpath.sv
// Datapath: CPU registers, bus cycle formation and the response register.
module iice_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iice_pkg::t_cmd       i_cmd,
    input  iice_pkg::t_req       i_req,
    output iice_pkg::t_dp_status o_status,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_stall,
    output iice_pkg::t_rsp       o_rsp
);
    import iice_pkg::*;

    logic [7:0]  r_a, r_x, r_y, r_sp, r_p;
    logic [15:0] r_pc;
    logic [7:0]  n_a, n_x, n_y, n_sp, n_p;
    logic [15:0] n_pc;
    logic [7:0]  r_b1, r_b2, r_b3;
    logic        r_rsp_vld;
    t_rsp        r_rsp, n_rsp;
    logic [15:0] bus_addr;
    logic [7:0]  wdata;

    assign o_status.out_free = !r_rsp_vld || !i_rsp_stall;
    assign o_rsp_valid       = r_rsp_vld;
    assign o_rsp             = r_rsp;

    // Register effects of the current bus cycle
    always_comb begin
        n_a  = r_a;
        n_x  = r_x;
        n_y  = r_y;
        n_sp = r_sp;
        n_p  = r_p;
        n_pc = r_pc;
        unique case (i_cmd.reg_op)
            REG_CLC:   n_p = r_p & ~FLAG_C;
            REG_CLI:   n_p = r_p & ~FLAG_I;
            REG_CLV:   n_p = r_p & ~FLAG_V;
            REG_CLD:   n_p = r_p & ~FLAG_D;
            REG_SEC:   n_p = r_p | FLAG_C;
            REG_SEI:   n_p = r_p | FLAG_I;
            REG_SED:   n_p = r_p | FLAG_D;
            REG_TAX: begin
                n_x = r_a;
                n_p = f_set_nz(r_p, r_a);
            end
            REG_TAY: begin
                n_y = r_a;
                n_p = f_set_nz(r_p, r_a);
            end
            REG_TXA: begin
                n_a = r_x;
                n_p = f_set_nz(r_p, r_x);
            end
            REG_TYA: begin
                n_a = r_y;
                n_p = f_set_nz(r_p, r_y);
            end
            REG_INX: begin
                n_x = r_x + 8'd1;
                n_p = f_set_nz(r_p, n_x);
            end
            REG_INY: begin
                n_y = r_y + 8'd1;
                n_p = f_set_nz(r_p, n_y);
            end
            REG_DEX: begin
                n_x = r_x - 8'd1;
                n_p = f_set_nz(r_p, n_x);
            end
            REG_DEY: begin
                n_y = r_y - 8'd1;
                n_p = f_set_nz(r_p, n_y);
            end
            REG_TXS:   n_sp = r_x;
            REG_TSX: begin
                n_x = r_sp;
                n_p = f_set_nz(r_p, r_sp);
            end
            REG_PLA: begin
                n_a = r_b1;
                n_p = f_set_nz(r_p, r_b1);
            end
            REG_PLP:   n_p = r_b1;
            REG_RTI_P: n_p = r_b1 & ~(FLAG_B | FLAG_U);
            default: ;
        endcase
        // stack pointer moves and PC updates never share a cycle with TXS
        if (i_cmd.sp_inc) n_sp = r_sp + 8'd1;
        if (i_cmd.sp_dec) n_sp = r_sp - 8'd1;
        if (i_cmd.pc_inc) n_pc = r_pc + 16'd1;
        unique case (i_cmd.pc_load)
            PCLD_LO_B1: n_pc = {r_pc[15:8], r_b1};
            PCLD_LO_B2: n_pc = {r_pc[15:8], r_b2};
            PCLD_HI_B2: n_pc = {r_b2, r_pc[7:0]};
            PCLD_HI_B3: n_pc = {r_b3, r_pc[7:0]};
            default: ;
        endcase
    end

    // Bus address and write data come from registers before the update
    always_comb begin
        unique case (i_cmd.addr_sel)
            ADDR_PC:     bus_addr = r_pc;
            ADDR_STACK:  bus_addr = {STACK_PAGE, r_sp};
            ADDR_VEC_LO: bus_addr = VEC_IRQ_LO;
            ADDR_VEC_HI: bus_addr = VEC_IRQ_HI;
            default:     bus_addr = r_pc;
        endcase
        unique case (i_cmd.wdata_sel)
            WD_PCH:    wdata = r_pc[15:8];
            WD_PCL:    wdata = r_pc[7:0];
            WD_PBRK:   wdata = r_p | FLAG_B | FLAG_U;
            WD_ACC:    wdata = r_a;
            WD_STATUS: wdata = r_p;
            default:   wdata = 8'h00;
        endcase
    end

    // Response: bus cycle plus register snapshot after it
    always_comb begin
        n_rsp.bus_address      = bus_addr;
        n_rsp.bus_is_write     = (i_cmd.wdata_sel != WD_NONE);
        n_rsp.bus_write_data   = wdata;
        n_rsp.last_cycle       = i_cmd.last;
        n_rsp.acc_out          = n_a;
        n_rsp.index_x_out      = n_x;
        n_rsp.index_y_out      = n_y;
        n_rsp.stack_ptr_out    = n_sp;
        n_rsp.status_out       = n_p;
        n_rsp.prog_counter_out = n_pc;
    end

    // CPU registers and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a       <= 8'h00;
            r_x       <= 8'h00;
            r_y       <= 8'h00;
            r_sp      <= 8'h00;
            r_p       <= 8'h00;
            r_pc      <= 16'h0000;
            r_rsp_vld <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_a       <= n_a;
                r_x       <= n_x;
                r_y       <= n_y;
                r_sp      <= n_sp;
                r_p       <= n_p;
                r_pc      <= n_pc;
                r_rsp_vld <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    // Payload registers: pulled bytes and response data
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_b1 <= i_req.pull_byte_first;
            r_b2 <= i_req.pull_byte_second;
            r_b3 <= i_req.pull_byte_third;
        end
        if (i_cmd.step) r_rsp <= n_rsp;
    end

endmodule

// File: design/implied_instruction_cycle_executor_top.sv
// Implied-mode instruction executor: one response per bus cycle of each instruction.
// Each request yields 2 to 7 responses, one per clock while the response side takes them:
// BRK 7, RTI and RTS 6, PLA and PLP 4, PHA and PHP 3, all others 2; codes past 24 yield none.
// After acceptance the controller steps through the bus cycles, one per clock while the output
// register is free; the next request is taken once the last bus cycle has entered the output
// register. Ignored codes leave the controller idle and yield no bus cycle.
// Reset (synchronous, active low) clears A, X, Y, SP, status and PC to zero and empties the output.
module implied_instruction_cycle_executor_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  iice_pkg::t_req   i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    output iice_pkg::t_rsp   o_rsp
);
    import iice_pkg::*;

    t_cmd       cmd;
    t_dp_status status;

    // Sequencer
    iice_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_type  (i_req.req_type),
        .o_req_stall (o_req_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Registers and bus cycle formation
    iice_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .o_status    (status),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

endmodule

// File: bench/implied_instruction_cycle_executor_top_tb.sv
// Self-checking bench for the implied-mode executor: per-bus-cycle scoreboard under random idling.
module implied_instruction_cycle_executor_top_tb;
    import iice_pkg::*;

    // Request codes past PLP that the block must ignore
    localparam logic [4:0] CODE_UNUSED_LO = 5'd25;
    localparam logic [4:0] CODE_UNUSED_HI = 5'd31;
    localparam int         NUM_CODES      = int'(INSTR_PLP) + 1;

    // Tracks architectural registers and the bus cycles each instruction must produce
    class bus_cycle_scoreboard;
        logic [7:0]  acc, xr, yr, sp, psr;
        logic [15:0] pc;
        t_rsp        bus_cycles_due[$];
        int          errors;
        int          cycles_seen;
        int          instr_hits[NUM_CODES];
        int          unknown_hits;

        function new();
            acc = '0;
            xr = '0;
            yr = '0;
            sp = '0;
            psr = '0;
            pc = '0;
            errors = 0;
            cycles_seen = 0;
            unknown_hits = 0;
            foreach (instr_hits[i]) instr_hits[i] = 0;
        endfunction

        // One bus cycle; register fields show the state after this cycle
        function void log_cycle(logic [15:0] addr, logic wr, logic [7:0] data, logic last);
            t_rsp c;
            c.bus_address      = addr;
            c.bus_is_write     = wr;
            c.bus_write_data   = wr ? data : 8'h00;
            c.last_cycle       = last;
            c.acc_out          = acc;
            c.index_x_out      = xr;
            c.index_y_out      = yr;
            c.stack_ptr_out    = sp;
            c.status_out       = psr;
            c.prog_counter_out = pc;
            bus_cycles_due.push_back(c);
        endfunction

        function void fetch_opcode(logic last);
            logic [15:0] addr;
            addr = pc;
            pc = pc + 16'd1;
            log_cycle(addr, 1'b0, 8'h00, last);
        endfunction

        function void push_byte(logic [7:0] v, logic last);
            logic [15:0] addr;
            addr = {STACK_PAGE, sp};
            sp = sp - 8'd1;
            log_cycle(addr, 1'b1, v, last);
        endfunction

        function void pull_dummy();
            logic [15:0] addr;
            addr = {STACK_PAGE, sp};
            sp = sp + 8'd1;
            log_cycle(addr, 1'b0, 8'h00, 1'b0);
        endfunction

        // N from bit 7, Z on zero; other flags kept
        function void load_nz(logic [7:0] v);
            psr = psr & ~(FLAG_N | FLAG_Z);
            if (v[7]) psr = psr | FLAG_N;
            if (v == 8'h00) psr = psr | FLAG_Z;
        endfunction

        // Accepted request: advance the registers and queue the bus cycles
        function void note_instruction(t_req r);
            logic [15:0] addr;
            logic        two_cycle;
            if (r.req_type > INSTR_PLP) begin
                unknown_hits++;
                return;
            end
            instr_hits[r.req_type]++;

            if (r.req_type == INSTR_BRK) begin
                fetch_opcode(1'b0);
                fetch_opcode(1'b0);
                push_byte(pc[15:8], 1'b0);
                push_byte(pc[7:0], 1'b0);
                push_byte(psr | FLAG_B | FLAG_U, 1'b0);
                pc[7:0] = r.pull_byte_first;
                log_cycle(VEC_IRQ_LO, 1'b0, 8'h00, 1'b0);
                pc[15:8] = r.pull_byte_second;
                psr = psr | FLAG_I;
                log_cycle(VEC_IRQ_HI, 1'b0, 8'h00, 1'b1);
                return;
            end

            two_cycle = (r.req_type <= INSTR_DEY) || (r.req_type == INSTR_TXS) ||
                        (r.req_type == INSTR_TSX);
            fetch_opcode(1'b0);
            // stack ops spend a dummy read at PC after the fetch
            if (!two_cycle) log_cycle(pc, 1'b0, 8'h00, 1'b0);

            case (r.req_type)
                INSTR_CLC: psr = psr & ~FLAG_C;
                INSTR_CLI: psr = psr & ~FLAG_I;
                INSTR_CLV: psr = psr & ~FLAG_V;
                INSTR_CLD: psr = psr & ~FLAG_D;
                INSTR_SEC: psr = psr | FLAG_C;
                INSTR_SEI: psr = psr | FLAG_I;
                INSTR_SED: psr = psr | FLAG_D;
                INSTR_TAX: begin xr = acc; load_nz(xr); end
                INSTR_TAY: begin yr = acc; load_nz(yr); end
                INSTR_TXA: begin acc = xr; load_nz(acc); end
                INSTR_TYA: begin acc = yr; load_nz(acc); end
                INSTR_INX: begin xr = xr + 8'd1; load_nz(xr); end
                INSTR_INY: begin yr = yr + 8'd1; load_nz(yr); end
                INSTR_DEX: begin xr = xr - 8'd1; load_nz(xr); end
                INSTR_DEY: begin yr = yr - 8'd1; load_nz(yr); end
                INSTR_TXS: sp = xr;
                INSTR_TSX: begin xr = sp; load_nz(xr); end
                INSTR_RTI: begin
                    pull_dummy();
                    addr = {STACK_PAGE, sp};
                    psr = r.pull_byte_first & ~(FLAG_B | FLAG_U);
                    sp = sp + 8'd1;
                    log_cycle(addr, 1'b0, 8'h00, 1'b0);
                    addr = {STACK_PAGE, sp};
                    pc[7:0] = r.pull_byte_second;
                    sp = sp + 8'd1;
                    log_cycle(addr, 1'b0, 8'h00, 1'b0);
                    pc[15:8] = r.pull_byte_third;
                    log_cycle({STACK_PAGE, sp}, 1'b0, 8'h00, 1'b1);
                end
                INSTR_RTS: begin
                    pull_dummy();
                    addr = {STACK_PAGE, sp};
                    pc[7:0] = r.pull_byte_first;
                    sp = sp + 8'd1;
                    log_cycle(addr, 1'b0, 8'h00, 1'b0);
                    pc[15:8] = r.pull_byte_second;
                    log_cycle({STACK_PAGE, sp}, 1'b0, 8'h00, 1'b0);
                    fetch_opcode(1'b1);
                end
                INSTR_PHA: push_byte(acc, 1'b1);
                INSTR_PHP: push_byte(psr, 1'b1);
                INSTR_PLA: begin
                    pull_dummy();
                    acc = r.pull_byte_first;
                    load_nz(acc);
                    log_cycle({STACK_PAGE, sp}, 1'b0, 8'h00, 1'b1);
                end
                INSTR_PLP: begin
                    pull_dummy();
                    psr = r.pull_byte_first;
                    log_cycle({STACK_PAGE, sp}, 1'b0, 8'h00, 1'b1);
                end
                default: ;
            endcase

            if (two_cycle) log_cycle(pc, 1'b0, 8'h00, 1'b1);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Accepted response: compare against the oldest pending bus cycle
        function void check_response(t_rsp got);
            t_rsp want;
            cycles_seen++;
            if (bus_cycles_due.size() == 0) begin
                $error("bus cycle at 0x%0h with nothing pending", got.bus_address);
                errors++;
                return;
            end
            want = bus_cycles_due.pop_front();
            check_field("bus_address", want.bus_address, got.bus_address);
            check_field("bus_is_write", 16'(want.bus_is_write), 16'(got.bus_is_write));
            check_field("bus_write_data", 16'(want.bus_write_data), 16'(got.bus_write_data));
            check_field("last_cycle", 16'(want.last_cycle), 16'(got.last_cycle));
            check_field("acc_out", 16'(want.acc_out), 16'(got.acc_out));
            check_field("index_x_out", 16'(want.index_x_out), 16'(got.index_x_out));
            check_field("index_y_out", 16'(want.index_y_out), 16'(got.index_y_out));
            check_field("stack_ptr_out", 16'(want.stack_ptr_out), 16'(got.stack_ptr_out));
            check_field("status_out", 16'(want.status_out), 16'(got.status_out));
            check_field("prog_counter_out", want.prog_counter_out, got.prog_counter_out);
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    t_req req_word  = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    t_rsp rsp_word;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    bus_cycle_scoreboard sb;

    implied_instruction_cycle_executor_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req_word),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp_word)
    );

    always #5 clk = ~clk;

    // Response side: check on accept, then pick the next stall
    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall) sb.check_response(rsp_word);
        rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Present one request, idling first at random, and hold it until taken
    task automatic issue(input t_req r);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= r;
        do @(posedge clk); while (req_stall);
        sb.note_instruction(r);
    endtask

    task automatic issue_op(input logic [4:0] code, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3);
        t_req r;
        r.req_type         = code;
        r.pull_byte_first  = b1;
        r.pull_byte_second = b2;
        r.pull_byte_third  = b3;
        issue(r);
    endtask

    // Pulled byte, often at a boundary value
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3) != 0) return 8'($urandom_range(255));
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            default: return 8'h7F;
        endcase
    endfunction

    // n valid instructions, with unknown codes sprinkled in as noise
    task automatic random_phase(input int n);
        int done;
        logic [4:0] code;
        done = 0;
        while (done < n) begin
            if ($urandom_range(99) < 5) begin
                code = 5'($urandom_range(CODE_UNUSED_HI, CODE_UNUSED_LO));
            end else begin
                code = 5'($urandom_range(INSTR_PLP));
                done++;
            end
            issue_op(code, pick_byte(), pick_byte(), pick_byte());
        end
    endtask

    // Hold off the request side until every pending bus cycle is out
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (sb.bus_cycles_due.size() != 0) @(posedge clk);
    endtask

    initial begin
        int codes_seen;
        int instr_total;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 37;
        rx_idle_pct = 79;

        // Directed: index wrap both ways, N/Z, every flag op, stack wrap, vector extremes
        issue_op(INSTR_DEX, 8'h00, 8'h00, 8'h00);
        issue_op(INSTR_INX, 8'hFF, 8'hFF, 8'hFF);
        issue_op(INSTR_DEY, 8'hA5, 8'h5A, 8'hA5);
        issue_op(INSTR_INY, 8'h00, 8'h00, 8'h00);
        issue_op(INSTR_PLA, 8'h80, 8'h11, 8'h22);
        issue_op(INSTR_TAX, 8'hFF, 8'h00, 8'hFF);
        issue_op(INSTR_TAY, 8'h00, 8'hFF, 8'h00);
        issue_op(INSTR_TXA, 8'h55, 8'hAA, 8'h55);
        issue_op(INSTR_TYA, 8'hAA, 8'h55, 8'hAA);
        issue_op(INSTR_PHA, 8'hC3, 8'h3C, 8'hC3);
        issue_op(INSTR_PHP, 8'h00, 8'h00, 8'h00);
        issue_op(INSTR_PLP, 8'hFF, 8'hEE, 8'hDD);
        issue_op(INSTR_CLC, 8'h00, 8'h00, 8'h00);
        issue_op(INSTR_CLI, 8'h00, 8'h00, 8'h00);
        issue_op(INSTR_CLV, 8'h00, 8'h00, 8'h00);
        issue_op(INSTR_CLD, 8'h00, 8'h00, 8'h00);
        issue_op(INSTR_SEC, 8'hFF, 8'hFF, 8'hFF);
        issue_op(INSTR_SEI, 8'hFF, 8'hFF, 8'hFF);
        issue_op(INSTR_SED, 8'hFF, 8'hFF, 8'hFF);
        issue_op(INSTR_NOP, 8'h12, 8'h34, 8'h56);
        issue_op(INSTR_RTI, 8'hFF, 8'hFF, 8'hFF);
        issue_op(INSTR_RTS, 8'h00, 8'h00, 8'hFF);
        issue_op(INSTR_BRK, 8'hFF, 8'hFF, 8'h00);
        issue_op(INSTR_TXS, 8'h00, 8'h00, 8'h00);
        issue_op(INSTR_TSX, 8'h00, 8'h00, 8'h00);
        issue_op(CODE_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF);

        random_phase(140);
        wait_for_drain();

        tx_idle_pct = 79;
        rx_idle_pct = 37;
        random_phase(140);
        wait_for_drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(140);
        wait_for_drain();
        repeat (16) @(posedge clk);

        codes_seen = 0;
        instr_total = 0;
        foreach (sb.instr_hits[i]) begin
            if (sb.instr_hits[i] > 0) codes_seen++;
            instr_total += sb.instr_hits[i];
        end
        $display("Ran %0d instructions touching %0d of %0d opcodes, plus %0d unused codes",
                 instr_total, codes_seen, NUM_CODES, sb.unknown_hits);
        $display("Compared %0d bus cycles, %0d field mismatches",
                 sb.cycles_seen, sb.errors);
        if (sb.errors == 0 && sb.bus_cycles_due.size() == 0) begin
            $display("PASS implied_instruction_cycle_executor_top");
        end else begin
            $display("FAIL implied_instruction_cycle_executor_top");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5000000;
        $display("FAIL implied_instruction_cycle_executor_top");
        $finish;
    end

endmodule

// File: sim.f
design/iice_pkg.sv
design/iice_ctrl.sv
design/iice_dpath.sv
design/implied_instruction_cycle_executor_top.sv
bench/implied_instruction_cycle_executor_top_tb.sv
